@@ rtl/core/gts_pkg.sv @@
`default_nettype none

package gts_pkg;

	// Build-time defaults for the top-level parameters.
	localparam int SAMPLES_PER_SYMBOL = 1920;
	localparam int PULSE_BT_TENTHS    = 20;

	// Field widths.
	localparam int CODE_W     = 4;
	localparam int SAMPLE_W   = 16;
	localparam int STEP_W     = 32;
	localparam int LEVEL_W    = 16;
	localparam int BASE_W     = 31;
	localparam int TONE_W     = 24;
	localparam int IDLE_W     = 3;
	localparam int WEIGHT_W   = 4;
	localparam int PULSE_W    = 31;
	localparam int ACC_W      = 35;
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 64;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// Serial multiplier operand widths.
	localparam int MA_W = 36;
	localparam int MB_W = 32;
	localparam int MP_W = MA_W + MB_W;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_BASE_STEP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TONE_STEP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_TONE = 2'd2;

	localparam logic [TONE_W-1:0]  TONE_STEP_RESET = 24'd2236962;
	localparam logic [LEVEL_W-1:0] LEVEL_ONE       = 16'd32768;

	localparam logic [63:0] GAUSS_K_Q32     = 64'd22919861047;
	localparam logic [63:0] TWO_RSQRTPI_Q30 = 64'd1211581161;
	localparam logic [63:0] PIHALF_Q30      = 64'd1686629713;
	localparam logic [63:0] ONE_Q62         = 64'h4000_0000_0000_0000;
	localparam logic [63:0] ONE_Q30         = 64'h0000_0000_4000_0000;

	// Constant divisors of the sine polynomial, highest term first, and the
	// reciprocal multipliers used in their place.
	localparam int N_TERMS = 5;
	localparam logic [7:0] DIV_D [N_TERMS] = '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
	localparam int DIV_S [N_TERMS] = '{38, 38, 37, 36, 34};
	localparam logic [MB_W-1:0] DIV_M [N_TERMS] = '{
		32'((64'd1 << 38) / 64'd110),
		32'((64'd1 << 38) / 64'd72),
		32'((64'd1 << 37) / 64'd42),
		32'((64'd1 << 36) / 64'd20),
		32'((64'd1 << 34) / 64'd6)
	};

	function automatic logic [63:0] mul_shr(input logic [63:0] a, input logic [63:0] b,
			input int s);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return 64'(p >> s);
	endfunction

	// erf of a nonnegative Q32 argument, in Q30.
	function automatic logic [63:0] erf_mag_q30(input logic [63:0] x);
		logic [63:0] x2, t, e, u, sum, r;
		int k, n;
		if (x == 64'd0)
			return 64'd0;
		if (x >= (64'd5 << 32))
			return ONE_Q30;
		x2 = mul_shr(x, x, 8);
		t = ONE_Q62;
		for (k = 20; k >= 1; k--)
			t = ONE_Q62 - mul_shr(x2, t, 62) / 64'(k);
		e = t;
		for (k = 0; k < 6; k++)
			e = mul_shr(e, e, 62);
		u = mul_shr(e, x, 32);
		sum = 64'd0;
		for (n = 0; n < 256 && u != 64'd0; n++) begin
			sum = sum + u;
			u = mul_shr(u, (64'd2 * x2) / 64'(2 * n + 3), 56);
		end
		r = mul_shr(sum, TWO_RSQRTPI_Q30, 62);
		return (r > ONE_Q30) ? ONE_Q30 : r;
	endfunction

	// One pulse entry from the two erf arguments and their signs.
	function automatic logic [PULSE_W-1:0] pulse_entry(input logic [63:0] xa, input logic na,
			input logic [63:0] xb, input logic nb);
		logic signed [65:0] ea, eb, d;
		ea = na ? -$signed({2'b00, erf_mag_q30(xa)}) : $signed({2'b00, erf_mag_q30(xa)});
		eb = nb ? -$signed({2'b00, erf_mag_q30(xb)}) : $signed({2'b00, erf_mag_q30(xb)});
		d = ea - eb;
		if (d < 0)
			d = '0;
		return PULSE_W'(d >>> 1);
	endfunction

	// Ramp level for a quarter-wave angle below one quarter turn.
	function automatic logic [LEVEL_W-1:0] ramp_level(input logic [63:0] ang);
		logic [63:0] x, x2, t, s;
		int k;
		x = (ang * PIHALF_Q30) >> 30;
		x2 = (x * x) >> 30;
		t = ONE_Q30;
		for (k = 10; k >= 2; k -= 2)
			t = ONE_Q30 - ((x2 * t) >> 30) / 64'(k * (k + 1));
		s = (x * t) >> 30;
		return LEVEL_W'((s * s + (64'd1 << 44)) >> 45);
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/gts_mult.sv @@
`default_nettype none

// Bit-serial shift-add multiplier: one bit of b per cycle, LSB first.
module gts_mult (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [gts_pkg::MA_W-1:0]  a,
	input  wire logic [gts_pkg::MB_W-1:0]  b,
	output logic                           busy,
	output logic [gts_pkg::MP_W-1:0]       prod
);

	localparam int CNT_W = $clog2(gts_pkg::MB_W + 1);

	logic [CNT_W-1:0]          cnt_q;
	logic [gts_pkg::MA_W-1:0]  a_q;
	logic [gts_pkg::MP_W-1:0]  acc_q;
	logic [gts_pkg::MA_W:0]    part;

	// The low half of the accumulator starts as b and shifts out as the
	// product shifts in from the top.
	assign part = {1'b0, acc_q[gts_pkg::MP_W-1:gts_pkg::MB_W]}
		+ (acc_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(gts_pkg::MB_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			acc_q <= {{gts_pkg::MA_W{1'b0}}, b};
		end else if (cnt_q != '0) begin
			acc_q <= {part, acc_q[gts_pkg::MB_W-1:1]};
		end
	end

	assign busy = (cnt_q != '0);
	assign prod = acc_q;

endmodule

`default_nettype wire

@@ rtl/core/gfsk_tone_synthesizer_unit.sv @@
// The block takes a new item only when it is through with the last one, since the
// bit-serial multiplier forms the 14 products of an item one after another.
// Reset (arst_n low, asynchronous) clears phase, sample position and control,
// and loads register defaults; the pulse ROM is constant, so no clearing pass.
`default_nettype none

module gfsk_tone_synthesizer_unit #(
	parameter int SAMPLES_PER_SYMBOL = gts_pkg::SAMPLES_PER_SYMBOL,
	parameter int PULSE_BT_TENTHS    = gts_pkg::PULSE_BT_TENTHS
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// Input items.
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	// prev_code [3:0], curr_code [7:4], next_code [11:8], zero [15:12].
	input  wire logic [gts_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// Result items.
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	// sample [15:0], phase_step [47:16], level [63:48].
	output logic [gts_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
	// symbol_end.
	output logic                                  m_axis_tlast,
	// Configuration writes.
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [gts_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [gts_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int N         = SAMPLES_PER_SYMBOL;
	localparam int RAMP_LEN  = N / 8;
	localparam int PULSE_LEN = 3 * N;
	localparam int POS_W     = $clog2(N);
	localparam int ROM_AW    = $clog2(PULSE_LEN);
	localparam int RI_W      = (RAMP_LEN > 1) ? $clog2(RAMP_LEN) : 1;
	localparam int TERM_W    = $clog2(gts_pkg::N_TERMS);

	// One-hot sequencer states.
	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_ROM    = 5'b00010,
		ST_MSTART = 5'b00100,
		ST_MWAIT  = 5'b01000,
		ST_FIN    = 5'b10000
	} state_t;

	// Which product the shared multiplier is forming.
	typedef enum logic [2:0] {
		OP_STEP, OP_X, OP_X2, OP_PROD, OP_DIV, OP_SIN
	} op_t;

	// Pulse ROM: each entry is computed at elaboration from the Gaussian
	// filtered frequency pulse, Q30.
	logic [gts_pkg::PULSE_W-1:0] pulse_w [PULSE_LEN];
	for (genvar gi = 0; gi < PULSE_LEN; gi++) begin : g_pulse
		localparam int JA = gi - N;
		localparam int JB = gi - 2 * N;
		localparam logic [63:0] XA = gts_pkg::GAUSS_K_Q32 * 64'(PULSE_BT_TENTHS)
			* 64'((JA < 0) ? -JA : JA) / 64'(10 * N);
		localparam logic [63:0] XB = gts_pkg::GAUSS_K_Q32 * 64'(PULSE_BT_TENTHS)
			* 64'((JB < 0) ? -JB : JB) / 64'(10 * N);
		localparam logic [gts_pkg::PULSE_W-1:0] VAL =
			gts_pkg::pulse_entry(XA, JA < 0, XB, JB < 0);
		assign pulse_w[gi] = VAL;
	end

	// Raised-cosine ramp table, one entry per ramp sample.
	logic [gts_pkg::LEVEL_W-1:0] ramp_w [RAMP_LEN];
	for (genvar gr = 0; gr < RAMP_LEN; gr++) begin : g_ramp
		localparam logic [63:0] ANG = (64'(gr) << 30) / 64'(RAMP_LEN);
		localparam logic [gts_pkg::LEVEL_W-1:0] VAL = gts_pkg::ramp_level(ANG);
		assign ramp_w[gr] = VAL;
	end

	state_t                        state_q;
	op_t                           op_q;
	logic [TERM_W-1:0]             term_q;
	logic [1:0]                    rd_cnt_q;
	logic [gts_pkg::BASE_W-1:0]    base_q;
	logic [gts_pkg::TONE_W-1:0]    tone_q;
	logic [gts_pkg::IDLE_W-1:0]    idle_q;
	logic [gts_pkg::STEP_W-1:0]    phase_q;
	logic [POS_W-1:0]              pos_q;
	logic                          out_valid_q;

	logic [POS_W-1:0]              s_q;
	logic [gts_pkg::WEIGHT_W-1:0]  wp_q, wc_q, wn_q;
	logic [gts_pkg::LEVEL_W-1:0]   lvl_q;
	logic                          end_q;
	logic [gts_pkg::PULSE_W-1:0]   pulse_q;
	logic [gts_pkg::ACC_W-1:0]     w_q;
	logic [gts_pkg::STEP_W-1:0]    step_q;
	logic                          neg_q;
	logic [30:0]                   r_q;
	logic [30:0]                   x_q;
	logic [31:0]                   x2_q;
	logic [30:0]                   t_q;
	logic [31:0]                   p_q;
	logic [30:0]                   sin_q;
	logic [gts_pkg::OUT_DATA_W-1:0] out_data_q;
	logic                          out_last_q;

	// Input decode.
	logic [gts_pkg::CODE_W-1:0]    pc, cc, nc;
	logic                          pg, cg, ng;
	logic [gts_pkg::WEIGHT_W-1:0]  wc_d;
	logic [gts_pkg::LEVEL_W-1:0]   lvl_d;
	logic [POS_W-1:0]              tail_pos;
	logic                          in_acc;

	assign pc = s_axis_tdata[3:0];
	assign cc = s_axis_tdata[7:4];
	assign nc = s_axis_tdata[11:8];
	// Codes above seven all mean a gap.
	assign pg = pc[3];
	assign cg = cc[3];
	assign ng = nc[3];
	assign tail_pos = POS_W'(N - 1) - pos_q;
	assign in_acc = s_axis_tvalid && s_axis_tready;

	always_comb begin
		// A gap takes its frequency from the next tone, else from the idle tone.
		if (!cg)
			wc_d = {1'b0, cc[2:0]} + 1'b1;
		else if (!ng)
			wc_d = {1'b0, nc[2:0]} + 1'b1;
		else
			wc_d = {1'b0, idle_q} + 1'b1;
		// The start ramp has priority over the end ramp.
		if (cg)
			lvl_d = '0;
		else if (pg && (32'(pos_q) < 32'(RAMP_LEN)))
			lvl_d = ramp_w[RI_W'(pos_q)];
		else if (ng && (32'(pos_q) >= 32'(N - RAMP_LEN)))
			lvl_d = ramp_w[RI_W'(tail_pos)];
		else
			lvl_d = gts_pkg::LEVEL_ONE;
	end

	// Pulse ROM read: the three taps of one item, oldest symbol first.
	logic [ROM_AW-1:0] rom_addr;
	always_comb begin
		case (rd_cnt_q)
			2'd0:    rom_addr = ROM_AW'(s_q) + ROM_AW'(2 * N);
			2'd1:    rom_addr = ROM_AW'(s_q) + ROM_AW'(N);
			default: rom_addr = ROM_AW'(s_q);
		endcase
	end

	always_ff @(posedge clk) begin
		pulse_q <= pulse_w[rom_addr];
	end

	logic [gts_pkg::WEIGHT_W-1:0] tap_w;
	always_comb begin
		case (rd_cnt_q)
			2'd1:    tap_w = wp_q;
			2'd2:    tap_w = wc_q;
			default: tap_w = wn_q;
		endcase
	end

	// Shared multiplier and its operand selection.
	logic                       mul_start;
	logic                       mul_busy;
	logic [gts_pkg::MA_W-1:0]   mul_a;
	logic [gts_pkg::MB_W-1:0]   mul_b;
	logic [gts_pkg::MP_W-1:0]   mul_p;

	assign mul_start = (state_q == ST_MSTART);

	always_comb begin
		case (op_q)
			OP_STEP: begin
				mul_a = gts_pkg::MA_W'(w_q);
				mul_b = gts_pkg::MB_W'(tone_q);
			end
			OP_X: begin
				mul_a = gts_pkg::MA_W'(r_q);
				mul_b = gts_pkg::MB_W'(gts_pkg::PIHALF_Q30);
			end
			OP_X2: begin
				mul_a = gts_pkg::MA_W'(x_q);
				mul_b = gts_pkg::MB_W'(x_q);
			end
			OP_PROD: begin
				mul_a = gts_pkg::MA_W'(x2_q);
				mul_b = gts_pkg::MB_W'(t_q);
			end
			OP_DIV: begin
				mul_a = gts_pkg::MA_W'(p_q);
				mul_b = gts_pkg::DIV_M[term_q];
			end
			OP_SIN: begin
				mul_a = gts_pkg::MA_W'(x_q);
				mul_b = gts_pkg::MB_W'(t_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	gts_mult u_mult (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.busy   (mul_busy),
		.prod   (mul_p)
	);

	// Writeback arithmetic for the product that just finished.
	logic [gts_pkg::MP_W-1:0]   step_rnd;
	logic [gts_pkg::STEP_W-1:0] step_d;
	logic [gts_pkg::STEP_W-1:0] phase_d;
	logic [30:0]                r_d;
	logic [31:0]                q0;
	logic [39:0]                q0d;
	logic [39:0]                rem;
	logic [31:0]                q;
	logic [30:0]                t_d;
	logic                       wb;

	assign wb = (state_q == ST_MWAIT) && !mul_busy;
	// Round the weighted tone step from Q30 and add the base step, mod 2^32.
	assign step_rnd = (mul_p + gts_pkg::MP_W'(64'd1 << 29)) >> 30;
	assign step_d = gts_pkg::STEP_W'(base_q) + gts_pkg::STEP_W'(step_rnd);
	assign phase_d = phase_q + step_d;
	// Fold the phase onto one quarter wave; odd quadrants run backward.
	assign r_d = phase_d[30] ? (31'(gts_pkg::ONE_Q30) - {1'b0, phase_d[29:0]})
		: {1'b0, phase_d[29:0]};
	// Reciprocal quotient can come out one short; one compare fixes it.
	assign q0 = 32'(mul_p >> gts_pkg::DIV_S[term_q]);
	assign q0d = 40'(q0) * 40'(gts_pkg::DIV_D[term_q]);
	assign rem = 40'(p_q) - q0d;
	assign q = (rem >= 40'(gts_pkg::DIV_D[term_q])) ? (q0 + 1'b1) : q0;
	assign t_d = 31'(gts_pkg::ONE_Q30 - 64'(q));

	// Output assembly: round the sine to Q1.15, limit it, apply the envelope.
	logic [15:0]                  mag_rnd;
	logic [14:0]                  mag15;
	logic [31:0]                  scaled;
	logic [gts_pkg::SAMPLE_W-1:0] mag_o;
	logic [gts_pkg::SAMPLE_W-1:0] sample_d;
	logic                         out_load;

	assign mag_rnd = 16'((32'(sin_q) + 32'd16384) >> 15);
	assign mag15 = (mag_rnd > 16'd32767) ? 15'h7fff : mag_rnd[14:0];
	assign scaled = (32'(mag15) * 32'(lvl_q) + 32'd16384) >> 15;
	assign mag_o = gts_pkg::SAMPLE_W'(scaled);
	assign sample_d = neg_q ? (16'd0 - mag_o) : mag_o;
	assign out_load = (state_q == ST_FIN) && (!out_valid_q || m_axis_tready);

	// Control, configuration and the block's running state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_STEP;
			term_q      <= '0;
			rd_cnt_q    <= '0;
			base_q      <= '0;
			tone_q      <= gts_pkg::TONE_STEP_RESET;
			idle_q      <= '0;
			phase_q     <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					gts_pkg::REG_BASE_STEP: base_q <= cfg_data[gts_pkg::BASE_W-1:0];
					gts_pkg::REG_TONE_STEP: tone_q <= cfg_data[gts_pkg::TONE_W-1:0];
					gts_pkg::REG_IDLE_TONE: idle_q <= cfg_data[gts_pkg::IDLE_W-1:0];
					default: ;
				endcase
			end

			if (out_load)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q  <= ST_ROM;
						rd_cnt_q <= '0;
						pos_q    <= (32'(pos_q) == N - 1) ? '0 : pos_q + 1'b1;
					end
				end
				ST_ROM: begin
					rd_cnt_q <= rd_cnt_q + 1'b1;
					if (rd_cnt_q == 2'd3) begin
						state_q <= ST_MSTART;
						op_q    <= OP_STEP;
					end
				end
				ST_MSTART: begin
					state_q <= ST_MWAIT;
				end
				ST_MWAIT: begin
					if (!mul_busy) begin
						state_q <= ST_MSTART;
						case (op_q)
							OP_STEP: begin
								phase_q <= phase_d;
								op_q    <= OP_X;
							end
							OP_X:    op_q <= OP_X2;
							OP_X2: begin
								op_q   <= OP_PROD;
								term_q <= '0;
							end
							OP_PROD: op_q <= OP_DIV;
							OP_DIV: begin
								if (32'(term_q) == gts_pkg::N_TERMS - 1) begin
									op_q <= OP_SIN;
								end else begin
									op_q   <= OP_PROD;
									term_q <= term_q + 1'b1;
								end
							end
							OP_SIN:  state_q <= ST_FIN;
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_FIN: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Item datapath.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			s_q   <= pos_q;
			wc_q  <= wc_d;
			wp_q  <= pg ? wc_d : ({1'b0, pc[2:0]} + 1'b1);
			wn_q  <= ng ? wc_d : ({1'b0, nc[2:0]} + 1'b1);
			lvl_q <= lvl_d;
			end_q <= (32'(pos_q) == N - 1);
			w_q   <= '0;
		end
		if ((state_q == ST_ROM) && (rd_cnt_q != 2'd0))
			w_q <= w_q + gts_pkg::ACC_W'(pulse_q) * gts_pkg::ACC_W'(tap_w);
		if (wb) begin
			case (op_q)
				OP_STEP: begin
					step_q <= step_d;
					neg_q  <= phase_d[31];
					r_q    <= r_d;
				end
				OP_X:    x_q <= 31'(mul_p >> 30);
				OP_X2: begin
					x2_q <= 32'(mul_p >> 30);
					t_q  <= 31'(gts_pkg::ONE_Q30);
				end
				OP_PROD: p_q <= 32'(mul_p >> 30);
				OP_DIV:  t_q <= t_d;
				OP_SIN:  sin_q <= 31'(mul_p >> 30);
				default: ;
			endcase
		end
		if (out_load) begin
			out_data_q <= {lvl_q, step_q, sample_d};
			out_last_q <= end_q;
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;
	assign cfg_ready     = 1'b1;

	// The multiplier is never left running between items.
	a_mult_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !mul_busy)
		else $error("multiplier busy while sequencer idle");

	// The sample position stays inside the symbol period.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(pos_q) < N)
		else $error("sample position out of range");

	// A new result only appears out of the final state.
	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == ST_FIN))
		else $error("result item raised outside the final state");

endmodule

`default_nettype wire

@@ dv/tb_gfsk_tone_synthesizer_unit.sv @@
`default_nettype none

module tb_gfsk_tone_synthesizer_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import gts_pkg::*;

	// The block's geometry, as built.
	localparam int SPS      = SAMPLES_PER_SYMBOL;
	localparam int RAMP     = SPS / 8;
	localparam int ROM_LEN  = 3 * SPS;
	localparam int CODE_GAP = 8;
	// The one index that decodes to no register; writes to it must be ignored.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	// No result may take longer than the block's latency plus the longest stall,
	// so a long quiet stretch means the block has hung.
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 600;
	localparam int RANDOM_ITEMS   = 1735;
	localparam int CALM_ITEMS     = 200;

	typedef struct {
		logic signed [SAMPLE_W-1:0] sample;
		logic [STEP_W-1:0]          phase_step;
		logic [LEVEL_W-1:0]         level;
		logic                       symbol_end;
	} tone_sample_t;

	// A directed row: the three codes, and optionally a level and sample that
	// are obvious from the codes and the position alone.
	typedef struct {
		logic [CODE_W-1:0] prev_code;
		logic [CODE_W-1:0] curr_code;
		logic [CODE_W-1:0] next_code;
		bit                known;
		logic [LEVEL_W-1:0] level;
		logic signed [SAMPLE_W-1:0] sample;
	} directed_row_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic m_axis_tlast;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	gfsk_tone_synthesizer_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Shadow copy of the block: the Gaussian pulse table, the registers, the
	// phase accumulator and the position within the symbol.
	logic [31:0] gauss_pulse [ROM_LEN];
	logic [30:0] base_step_q;
	logic [23:0] tone_step_q;
	logic [2:0]  idle_tone_q;
	logic [31:0] phase_q;
	int unsigned position_q;

	tone_sample_t expected_samples [$];
	int mismatch_count;
	int idle_cycles;
	bit calm;

	// floor(a * b / 2^sh) on a full 128-bit product.
	function automatic logic [63:0] scaled_product(logic [63:0] a, logic [63:0] b, int sh);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return 64'(p >> sh);
	endfunction

	// erf of a nonnegative Q32 argument, result in Q30. The exponential is a
	// Horner series of exp(-x^2/64) raised to the 64th power by six squarings.
	function automatic logic [63:0] erf_q30(logic [63:0] x);
		logic [63:0] xsq, horner, term, acc, r;
		int k;
		if (x == 0)
			return 0;
		if (x >= (64'd5 << 32))
			return ONE_Q30;
		xsq = scaled_product(x, x, 8);
		horner = ONE_Q62;
		for (k = 20; k >= 1; k--)
			horner = ONE_Q62 - scaled_product(xsq, horner, 62) / 64'(k);
		for (k = 0; k < 6; k++)
			horner = scaled_product(horner, horner, 62);
		term = scaled_product(horner, x, 32);
		acc = 0;
		for (k = 0; k < 256 && term != 0; k++) begin
			acc += term;
			term = scaled_product(term, (64'd2 * xsq) / 64'(2 * k + 3), 56);
		end
		r = scaled_product(acc, TWO_RSQRTPI_Q30, 62);
		return (r > ONE_Q30) ? ONE_Q30 : r;
	endfunction

	// Signed erf at sample offset j from the pulse center.
	function automatic longint erf_at_offset(int j);
		logic [63:0] mag, x;
		longint e;
		mag = 64'(j < 0 ? -j : j);
		x = GAUSS_K_Q32 * 64'(PULSE_BT_TENTHS) * mag / (64'd10 * 64'(SPS));
		e = longint'(erf_q30(x));
		return (j < 0) ? -e : e;
	endfunction

	// Quarter-wave Taylor sine of a 32-bit phase, signed Q30.
	function automatic longint sine_q30(logic [31:0] ph);
		logic [1:0] quad;
		logic [63:0] r, x, xsq, t, s;
		int k;
		quad = ph[31:30];
		r = {34'd0, ph[29:0]};
		if (quad[0])
			r = ONE_Q30 - r;
		x = (r * PIHALF_Q30) >> 30;
		xsq = (x * x) >> 30;
		t = ONE_Q30;
		for (k = 10; k >= 2; k -= 2)
			t = ONE_Q30 - ((xsq * t) >> 30) / 64'(k * (k + 1));
		s = (x * t) >> 30;
		return quad[1] ? -longint'(s) : longint'(s);
	endfunction

	// Raised-cosine ramp: sin^2 of a quarter turn scaled over the ramp length.
	function automatic logic [LEVEL_W-1:0] envelope_ramp(int unsigned n);
		logic [31:0] ang;
		logic [63:0] s;
		ang = 32'((64'(n) << 30) / 64'(RAMP));
		s = 64'(sine_q30(ang));
		return LEVEL_W'((s * s + (64'd1 << 44)) >> 45);
	endfunction

	// Works out the sample for one input item and advances the shadow state.
	function automatic tone_sample_t synthesize_sample(logic [CODE_W-1:0] pc,
			logic [CODE_W-1:0] cc, logic [CODE_W-1:0] nc);
		tone_sample_t o;
		bit pg, cg, ng;
		logic [63:0] wc, wp, wn, w, step, mag;
		longint sn;
		int unsigned s;
		pg = pc >= CODE_GAP;
		cg = cc >= CODE_GAP;
		ng = nc >= CODE_GAP;
		s = position_q;
		// A gap borrows its frequency from the next tone, or else the idle tone;
		// a gap neighbour weighs like the current symbol.
		wc = !cg ? 64'(cc) + 1 : (!ng ? 64'(nc) + 1 : 64'(idle_tone_q) + 1);
		wp = pg ? wc : 64'(pc) + 1;
		wn = ng ? wc : 64'(nc) + 1;
		w = 64'(gauss_pulse[s + 2 * SPS]) * wp + 64'(gauss_pulse[s + SPS]) * wc
			+ 64'(gauss_pulse[s]) * wn;
		step = 64'(base_step_q) + ((64'(tone_step_q) * w + (64'd1 << 29)) >> 30);
		o.phase_step = step[31:0];
		phase_q = phase_q + step[31:0];
		if (cg)
			o.level = '0;
		else if (pg && s < RAMP)
			o.level = envelope_ramp(s);
		else if (ng && s >= SPS - RAMP)
			o.level = envelope_ramp(SPS - s - 1);
		else
			o.level = LEVEL_ONE;
		sn = sine_q30(phase_q);
		mag = (64'(sn < 0 ? -sn : sn) + (64'd1 << 14)) >> 15;
		if (mag > 32767)
			mag = 32767;
		mag = (mag * 64'(o.level) + (64'd1 << 14)) >> 15;
		o.sample = (sn < 0) ? -SAMPLE_W'(mag) : SAMPLE_W'(mag);
		o.symbol_end = (s == SPS - 1);
		position_q = (s + 1 >= SPS) ? 0 : s + 1;
		return o;
	endfunction

	task automatic sender_gap();
		if (!calm && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 12)) @(negedge clk);
	endtask

	// Offers one item and waits for its acceptance; the expectation is formed
	// at the accepting edge so that it sees the registers in force then.
	task automatic send_codes(logic [CODE_W-1:0] pc, logic [CODE_W-1:0] cc,
			logic [CODE_W-1:0] nc, bit known, logic [LEVEL_W-1:0] lvl,
			logic signed [SAMPLE_W-1:0] smp);
		tone_sample_t e;
		sender_gap();
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {4'd0, nc, cc, pc};
		do
			@(posedge clk);
		while (!s_axis_tready);
		e = synthesize_sample(pc, cc, nc);
		if (known) begin
			e.level = lvl;
			e.sample = smp;
		end
		expected_samples.push_back(e);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			REG_BASE_STEP: base_step_q = val[30:0];
			REG_TONE_STEP: tone_step_q = val[23:0];
			REG_IDLE_TONE: idle_tone_q = val[2:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Holds the sender back until every outstanding sample has come out.
	task automatic wait_until_idle();
		while (expected_samples.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Mostly tones, with ordinary gaps and the out-of-range codes that also
	// count as gaps.
	function automatic logic [CODE_W-1:0] pick_code();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return CODE_W'($urandom_range(0, 7));
		else if (r < 88)
			return CODE_W'(CODE_GAP);
		else
			return CODE_W'($urandom_range(9, 15));
	endfunction

	// Runs of items share one symbol triple, as a real symbol stream would,
	// with the occasional lone item of unrelated codes.
	task automatic random_phase(int count);
		logic [CODE_W-1:0] pc, cc, nc;
		int run;
		run = 0;
		for (int i = 0; i < count; i++) begin
			if (run == 0) begin
				pc = pick_code();
				cc = pick_code();
				nc = pick_code();
				run = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(1, 60);
			end
			run--;
			calm = (i >= count - CALM_ITEMS) && (count > CALM_ITEMS);
			send_codes(pc, cc, nc, 1'b0, '0, '0);
		end
		calm = 1'b0;
	endtask

	// The receiver stalls in bursts, except in the final calm stretch.
	int stall_left;
	always @(negedge clk) begin
		if (!arst_n || calm) begin
			m_axis_tready <= 1'b1;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			m_axis_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 15) == 0) begin
			m_axis_tready <= 1'b0;
			stall_left <= $urandom_range(0, 11);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Each result is compared against the oldest expectation.
	always @(posedge clk) begin
		tone_sample_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_samples.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected sample: tdata %h tlast %b", m_axis_tdata, m_axis_tlast);
			end else begin
				e = expected_samples.pop_front();
				if (m_axis_tdata[15:0] !== e.sample || m_axis_tdata[47:16] !== e.phase_step
						|| m_axis_tdata[63:48] !== e.level || m_axis_tlast !== e.symbol_end) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display({"sample mismatch: expected sample %0d step %h level %0d end %b,",
							" got sample %0d step %h level %0d end %b"},
							e.sample, e.phase_step, e.level, e.symbol_end,
							$signed(m_axis_tdata[15:0]), m_axis_tdata[47:16],
							m_axis_tdata[63:48], m_axis_tlast);
				end
			end
		end
	end

	// Counts cycles in which no item moves on any channel.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Directed rows. The first lands on position zero after a gap, where the
	// start ramp is exactly zero; gaps in the current slot always give level
	// and sample zero. The rest cover extreme codes and the out-of-range codes.
	directed_row_t directed_rows [] = '{
		'{4'd8,  4'd5,  4'd2,  1'b1, 16'd0, 16'sd0},
		'{4'd8,  4'd8,  4'd8,  1'b1, 16'd0, 16'sd0},
		'{4'd0,  4'd8,  4'd15, 1'b1, 16'd0, 16'sd0},
		'{4'd15, 4'd15, 4'd7,  1'b1, 16'd0, 16'sd0},
		'{4'd9,  4'd12, 4'd3,  1'b1, 16'd0, 16'sd0},
		'{4'd0,  4'd0,  4'd0,  1'b0, 16'd0, 16'sd0},
		'{4'd7,  4'd7,  4'd7,  1'b0, 16'd0, 16'sd0},
		'{4'd0,  4'd7,  4'd0,  1'b0, 16'd0, 16'sd0},
		'{4'd7,  4'd0,  4'd7,  1'b0, 16'd0, 16'sd0},
		'{4'd8,  4'd3,  4'd8,  1'b0, 16'd0, 16'sd0},
		'{4'd10, 4'd6,  4'd11, 1'b0, 16'd0, 16'sd0},
		'{4'd1,  4'd2,  4'd14, 1'b0, 16'd0, 16'sd0},
		'{4'd13, 4'd4,  4'd5,  1'b0, 16'd0, 16'sd0},
		'{4'd6,  4'd1,  4'd8,  1'b0, 16'd0, 16'sd0},
		'{4'd3,  4'd8,  4'd8,  1'b0, 16'd0, 16'sd0}
	};

	initial begin
		longint d;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_BASE_STEP;
		cfg_data = '0;
		mismatch_count = 0;
		calm = 1'b0;
		// The pulse is the difference of two erf curves one symbol apart.
		for (int i = 0; i < ROM_LEN; i++) begin
			d = erf_at_offset(i - SPS) - erf_at_offset(i - 2 * SPS);
			if (d < 0)
				d = 0;
			gauss_pulse[i] = 32'(d >>> 1);
		end
		base_step_q = '0;
		tone_step_q = TONE_STEP_RESET;
		idle_tone_q = '0;
		phase_q = '0;
		position_q = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Register defaults first.
		foreach (directed_rows[i])
			send_codes(directed_rows[i].prev_code, directed_rows[i].curr_code,
				directed_rows[i].next_code, directed_rows[i].known,
				directed_rows[i].level, directed_rows[i].sample);
		wait_until_idle();

		// Largest steps and idle tone; the write to the unused index must change nothing.
		write_register(REG_BASE_STEP, 32'hFFFF_FFFF);
		write_register(REG_TONE_STEP, 32'hFFFF_FFFF);
		write_register(REG_IDLE_TONE, 32'hFFFF_FFFF);
		write_register(REG_UNUSED, 32'h1234_5678);
		random_phase(RANDOM_ITEMS / 4);
		wait_until_idle();

		// Zero steps, so the phase stands still.
		write_register(REG_BASE_STEP, 32'd0);
		write_register(REG_TONE_STEP, 32'd0);
		write_register(REG_IDLE_TONE, 32'd3);
		random_phase(RANDOM_ITEMS / 8);
		wait_until_idle();

		// Random settings for the long remainder.
		write_register(REG_BASE_STEP, $urandom());
		write_register(REG_TONE_STEP, $urandom());
		write_register(REG_IDLE_TONE, $urandom());
		random_phase(RANDOM_ITEMS - RANDOM_ITEMS / 4 - RANDOM_ITEMS / 8);

		wait_until_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_samples.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

`default_nettype wire
